// ===== hw/rtl/esm_pkg.sv =====
// Shared constants, codes and control/status structs of the ELLPACK matrix engine.
package esm_pkg;

  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_SLOTS  = 8;
  localparam int SLOT_TOTAL = MAX_ROWS * MAX_SLOTS;

  localparam int ROW_W   = 10;                        // row field width
  localparam int COL_W   = 10;                        // col field width
  localparam int CNT_W   = 11;                        // row/col count registers
  localparam int SPR_W   = 4;                         // slots_per_row register
  localparam int VAL_W   = 32;
  localparam int RIDX_W  = $clog2(MAX_ROWS);
  localparam int SADDR_W = $clog2(SLOT_TOTAL);
  localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int J_W     = $clog2(MAX_SLOTS + 1);
  localparam int ACC_W   = 2 * VAL_W - 16 + J_W + 1;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 11;

  localparam logic [CFG_IW-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SLOTS = 2'd2;

  typedef enum logic [2:0] {
    ACT_SET   = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_GET   = 3'd2,
    ACT_ZROW  = 3'd3,
    ACT_ZCOL  = 3'd4,
    ACT_LOADX = 3'd5,
    ACT_PROD  = 3'd6,
    ACT_CLEAR = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_INDEX  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } st_t;

  typedef enum logic [2:0] {
    WK_NEW, WK_VAL, WK_ADD, WK_ZROW, WK_ZCOL
  } wr_kind_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_SRD, S_SEV, S_XRD, S_ACC, S_CLR, S_DONE
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } slot_t;

  typedef struct packed {
    logic     load_item;
    logic     row_clear;
    logic     row_inc;
    logic     j_clear;
    logic     j_inc;
    logic     slot_wr;
    wr_kind_t wr_kind;
    logic     vbit_set;
    logic     vrow_clear;
    logic     x_clear;
    logic     x_load;
    logic     prod_en;
    logic     acc_add;
    logic     res_get;
    logic     res_prod;
    logic     out_load;
    st_t      out_status;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic idx_bad;
    logic slot_end;
    logic slot_live;
    logic col_match;
    logic row_last;
    logic rows_none;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/ellpack_sparse_matrix_engine.sv =====
// Top level of the ELLPACK sparse matrix engine: controller plus datapath.
//
// One command word enters on the in_ channel (valid/ready) and exactly one
// result word leaves on the out_ channel (status, result_value). Config
// registers row_count, col_count and slots_per_row are written through
// cfg_wr_en/cfg_index/cfg_data; the user must do so only while idle (not enforced).
// One word is worked at a time. Work per word, by action:
//   bad index, load x:            ends at dispatch
//   set/add/get:                  scan slots to a free or matching one, or the row's end
//   zero row:                     scan each live slot in order
//   row product:                  per live slot: read, x lookup, multiply, add
//   zero column:                  scan the live slots of every configured row
//   clear:                        sweep all 1024 rows, one valid row per cycle
// Each slot is read in S_SRD and judged in S_SEV; this pair sets the scan rate.
// After reset a sweep over all 1024 rows zeroes the valid rows and the x vector;
// in_ready stays low during it. The result register frees the datapath:
// if the receiver stalls, a finished word waits there and the block holds
// the next word in its last state until the register can take it.
module ellpack_sparse_matrix_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_action,
  input  logic [esm_pkg::ROW_W-1:0]     in_row,
  input  logic [esm_pkg::COL_W-1:0]     in_col,
  input  logic signed [esm_pkg::VAL_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic signed [esm_pkg::VAL_W-1:0] out_result_value,
  input  logic                          cfg_wr_en,
  input  logic [esm_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [esm_pkg::CFG_DW-1:0]    cfg_data
);

  esm_pkg::cmd_t cmd;
  esm_pkg::sts_t sts;

  esm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  esm_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_value         (in_value),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ===== hw/rtl/esm_datapath.sv =====
// Datapath: config registers, slot/valid/x memories, scan counters, MAC and result register.
module esm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [esm_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [esm_pkg::CFG_DW-1:0]    cfg_data,
  input  logic [2:0]                    in_action,
  input  logic [esm_pkg::ROW_W-1:0]     in_row,
  input  logic [esm_pkg::COL_W-1:0]     in_col,
  input  logic signed [esm_pkg::VAL_W-1:0] in_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic signed [esm_pkg::VAL_W-1:0] out_result_value,
  input  esm_pkg::cmd_t                 cmd,
  output esm_pkg::sts_t                 sts
);

  localparam logic [esm_pkg::CNT_W-1:0] ROWS_MAX = esm_pkg::CNT_W'(esm_pkg::MAX_ROWS);
  localparam logic [esm_pkg::CNT_W-1:0] COLS_MAX = esm_pkg::CNT_W'(esm_pkg::MAX_COLS);
  localparam logic [esm_pkg::SPR_W-1:0] SPR_MAX  = esm_pkg::SPR_W'(esm_pkg::MAX_SLOTS);
  localparam logic [esm_pkg::RIDX_W-1:0] ROW_TOP = esm_pkg::RIDX_W'(esm_pkg::MAX_ROWS - 1);

  logic [esm_pkg::CNT_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [esm_pkg::SPR_W-1:0] slots_cfg_r;

  esm_pkg::act_t             act_r;
  logic [esm_pkg::ROW_W-1:0] row_item_r;
  logic [esm_pkg::COL_W-1:0] col_item_r;
  logic signed [esm_pkg::VAL_W-1:0] val_r;

  logic [esm_pkg::RIDX_W-1:0] row_r, row_nxt;
  logic [esm_pkg::J_W-1:0]    j_r;
  logic signed [esm_pkg::ACC_W-1:0] acc_r;
  logic signed [2*esm_pkg::VAL_W-1:0] prod_r;
  logic signed [esm_pkg::VAL_W-1:0] res_r;
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic signed [esm_pkg::VAL_W-1:0] out_res_r;

  esm_pkg::slot_t smem [esm_pkg::SLOT_TOTAL];
  logic [esm_pkg::MAX_SLOTS-1:0] vmem [esm_pkg::MAX_ROWS];
  logic [esm_pkg::VAL_W-1:0]     xmem [esm_pkg::MAX_COLS];

  esm_pkg::slot_t                slot_q, slot_wd;
  logic [esm_pkg::MAX_SLOTS-1:0] vword_q;
  logic signed [esm_pkg::VAL_W-1:0] x_q;

  logic [esm_pkg::CNT_W-1:0] nr, nc;
  logic [esm_pkg::SPR_W-1:0] ns;
  logic [esm_pkg::SADDR_W-1:0] saddr;
  logic [esm_pkg::SLOT_W-1:0]  jidx;
  logic row_bad, col_bad;
  logic signed [esm_pkg::VAL_W:0] sum;
  logic signed [esm_pkg::VAL_W-1:0] sum_sat, acc_sat, sv;
  logic signed [2*esm_pkg::VAL_W-17:0] term;

  assign nr = (rows_cfg_r < ROWS_MAX) ? rows_cfg_r : ROWS_MAX;
  assign nc = (cols_cfg_r < COLS_MAX) ? cols_cfg_r : COLS_MAX;
  assign ns = (slots_cfg_r < SPR_MAX) ? slots_cfg_r : SPR_MAX;

  assign saddr = esm_pkg::SADDR_W'(row_r * esm_pkg::MAX_SLOTS) + esm_pkg::SADDR_W'(j_r);
  assign jidx  = j_r[esm_pkg::SLOT_W-1:0];
  assign sv    = slot_q.val;

  assign row_bad = {1'b0, row_item_r} >= nr;
  assign col_bad = {1'b0, col_item_r} >= nc;

  always_comb begin
    sts.act        = act_r;
    sts.slot_end   = j_r >= esm_pkg::J_W'(ns);
    sts.slot_live  = vword_q[jidx];
    sts.col_match  = slot_q.col == col_item_r;
    sts.row_last   = esm_pkg::CNT_W'(row_r) == nr - 1'b1;
    sts.rows_none  = nr == '0;
    sts.sweep_last = row_r == ROW_TOP;
    sts.out_free   = !out_valid_r || out_ready;
    case (act_r)
      esm_pkg::ACT_SET, esm_pkg::ACT_ADD, esm_pkg::ACT_GET: sts.idx_bad = row_bad || col_bad;
      esm_pkg::ACT_ZROW, esm_pkg::ACT_PROD:                 sts.idx_bad = row_bad;
      esm_pkg::ACT_ZCOL, esm_pkg::ACT_LOADX:                sts.idx_bad = col_bad;
      default:                                              sts.idx_bad = 1'b0;
    endcase
  end

  // saturating add and final dot-product clamp
  always_comb begin
    sum = {sv[esm_pkg::VAL_W-1], sv} + {val_r[esm_pkg::VAL_W-1], val_r};
    if (sum[esm_pkg::VAL_W] != sum[esm_pkg::VAL_W-1])
      sum_sat = sum[esm_pkg::VAL_W] ? {1'b1, {(esm_pkg::VAL_W-1){1'b0}}}
                                    : {1'b0, {(esm_pkg::VAL_W-1){1'b1}}};
    else
      sum_sat = sum[esm_pkg::VAL_W-1:0];
    if (acc_r > esm_pkg::ACC_W'(signed'({1'b0, {(esm_pkg::VAL_W-1){1'b1}}})))
      acc_sat = {1'b0, {(esm_pkg::VAL_W-1){1'b1}}};
    else if (acc_r < -esm_pkg::ACC_W'(signed'({1'b0, 1'b1, {(esm_pkg::VAL_W-1){1'b0}}})))
      acc_sat = {1'b1, {(esm_pkg::VAL_W-1){1'b0}}};
    else
      acc_sat = acc_r[esm_pkg::VAL_W-1:0];
    term = prod_r[2*esm_pkg::VAL_W-1:16];   // floor shift by 16
  end

  always_comb begin
    slot_wd.col = slot_q.col;
    case (cmd.wr_kind)
      esm_pkg::WK_NEW: begin
        slot_wd.col = col_item_r;
        slot_wd.val = val_r;
      end
      esm_pkg::WK_VAL:  slot_wd.val = val_r;
      esm_pkg::WK_ADD:  slot_wd.val = sum_sat;
      esm_pkg::WK_ZROW: slot_wd.val = (slot_q.col == row_item_r) ? val_r : '0;
      esm_pkg::WK_ZCOL: slot_wd.val = (row_r == col_item_r) ? val_r : '0;
      default:          slot_wd.val = '0;
    endcase
  end

  always_comb begin
    row_nxt = row_r;
    if (cmd.load_item)      row_nxt = in_row;
    else if (cmd.row_clear) row_nxt = '0;
    else if (cmd.row_inc)   row_nxt = row_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_wr) smem[saddr] <= slot_wd;
    slot_q <= smem[saddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.vrow_clear)    vmem[row_r] <= '0;
    else if (cmd.vbit_set) vmem[row_r] <= vword_q | (esm_pkg::MAX_SLOTS'(1) << jidx);
    vword_q <= vmem[row_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.x_clear)     xmem[row_r[esm_pkg::COL_W-1:0]] <= '0;
    else if (cmd.x_load) xmem[col_item_r] <= val_r;
    x_q <= xmem[slot_q.col];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r  <= ROWS_MAX;
      cols_cfg_r  <= COLS_MAX;
      slots_cfg_r <= SPR_MAX;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          esm_pkg::CFG_ROWS:  rows_cfg_r  <= cfg_data;
          esm_pkg::CFG_COLS:  cols_cfg_r  <= cfg_data;
          esm_pkg::CFG_SLOTS: slots_cfg_r <= cfg_data[esm_pkg::SPR_W-1:0];
          default: ;
        endcase
      end
      row_r <= row_nxt;
      if (cmd.out_load)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r      <= esm_pkg::act_t'(in_action);
      row_item_r <= in_row;
      col_item_r <= in_col;
      val_r      <= in_value;
      acc_r      <= '0;
      res_r      <= '0;
    end else begin
      if (cmd.acc_add)  acc_r <= acc_r + esm_pkg::ACC_W'(term);
      if (cmd.res_get)  res_r <= sv;
      if (cmd.res_prod) res_r <= acc_sat;
    end
    if (cmd.load_item || cmd.j_clear) j_r <= '0;
    else if (cmd.j_inc)               j_r <= j_r + 1'b1;
    if (cmd.prod_en) prod_r <= sv * x_q;
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_res_r    <= res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_res_r;

endmodule

// ===== hw/rtl/esm_ctrl.sv =====
// Controller FSM: sequences slot scans, column walks, sweeps and result hand-off.
module esm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  esm_pkg::sts_t sts,
  output esm_pkg::cmd_t cmd
);

  esm_pkg::state_t state_r, state_nxt;
  esm_pkg::st_t    st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esm_pkg::S_INIT;
      st_r    <= esm_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.wr_kind    = esm_pkg::WK_NEW;
    cmd.out_status = st_r;
    case (state_r)
      esm_pkg::S_INIT: begin
        // power-up sweep clears valid words and x
        cmd.vrow_clear = 1'b1;
        cmd.x_clear    = 1'b1;
        cmd.row_inc    = 1'b1;
        if (sts.sweep_last) state_nxt = esm_pkg::S_IDLE;
      end
      esm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          st_nxt        = esm_pkg::ST_OK;
          state_nxt     = esm_pkg::S_DISP;
        end
      end
      esm_pkg::S_DISP: begin
        if (sts.idx_bad) begin
          st_nxt    = esm_pkg::ST_INDEX;
          state_nxt = esm_pkg::S_DONE;
        end else begin
          case (sts.act)
            esm_pkg::ACT_ZCOL: begin
              cmd.row_clear = 1'b1;
              state_nxt = sts.rows_none ? esm_pkg::S_DONE : esm_pkg::S_SRD;
            end
            esm_pkg::ACT_LOADX: begin
              cmd.x_load = 1'b1;
              state_nxt  = esm_pkg::S_DONE;
            end
            esm_pkg::ACT_CLEAR: begin
              cmd.row_clear = 1'b1;
              state_nxt     = esm_pkg::S_CLR;
            end
            default: state_nxt = esm_pkg::S_SEV;
          endcase
        end
      end
      esm_pkg::S_SRD: state_nxt = esm_pkg::S_SEV;
      esm_pkg::S_SEV: begin
        case (sts.act)
          esm_pkg::ACT_SET, esm_pkg::ACT_ADD, esm_pkg::ACT_GET: begin
            state_nxt = esm_pkg::S_DONE;
            if (sts.slot_end) begin
              st_nxt = (sts.act == esm_pkg::ACT_GET) ? esm_pkg::ST_ABSENT : esm_pkg::ST_FULL;
            end else if (!sts.slot_live) begin
              if (sts.act != esm_pkg::ACT_GET) begin
                cmd.slot_wr  = 1'b1;
                cmd.wr_kind  = esm_pkg::WK_NEW;
                cmd.vbit_set = 1'b1;
              end
            end else if (sts.col_match) begin
              case (sts.act)
                esm_pkg::ACT_SET: begin
                  cmd.slot_wr = 1'b1;
                  cmd.wr_kind = esm_pkg::WK_VAL;
                end
                esm_pkg::ACT_ADD: begin
                  cmd.slot_wr = 1'b1;
                  cmd.wr_kind = esm_pkg::WK_ADD;
                end
                default: cmd.res_get = 1'b1;
              endcase
            end else begin
              cmd.j_inc = 1'b1;
              state_nxt = esm_pkg::S_SRD;
            end
          end
          esm_pkg::ACT_ZROW: begin
            if (sts.slot_end || !sts.slot_live) begin
              state_nxt = esm_pkg::S_DONE;
            end else begin
              cmd.slot_wr = 1'b1;
              cmd.wr_kind = esm_pkg::WK_ZROW;
              cmd.j_inc   = 1'b1;
              state_nxt   = esm_pkg::S_SRD;
            end
          end
          esm_pkg::ACT_ZCOL: begin
            if (sts.slot_end || !sts.slot_live) begin
              if (sts.row_last) begin
                state_nxt = esm_pkg::S_DONE;
              end else begin
                cmd.row_inc = 1'b1;
                cmd.j_clear = 1'b1;
                state_nxt   = esm_pkg::S_SRD;
              end
            end else begin
              cmd.slot_wr = sts.col_match;
              cmd.wr_kind = esm_pkg::WK_ZCOL;
              cmd.j_inc   = 1'b1;
              state_nxt   = esm_pkg::S_SRD;
            end
          end
          default: begin
            if (sts.slot_end || !sts.slot_live) begin
              cmd.res_prod = 1'b1;
              state_nxt    = esm_pkg::S_DONE;
            end else begin
              state_nxt = esm_pkg::S_XRD;
            end
          end
        endcase
      end
      esm_pkg::S_XRD: begin
        cmd.prod_en = 1'b1;
        state_nxt   = esm_pkg::S_ACC;
      end
      esm_pkg::S_ACC: begin
        cmd.acc_add = 1'b1;
        cmd.j_inc   = 1'b1;
        state_nxt   = esm_pkg::S_SRD;
      end
      esm_pkg::S_CLR: begin
        cmd.vrow_clear = 1'b1;
        cmd.row_inc    = 1'b1;
        if (sts.sweep_last) state_nxt = esm_pkg::S_DONE;
      end
      esm_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = esm_pkg::S_IDLE;
        end
      end
      default: state_nxt = esm_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/esm_checker.sv =====
// Port-level checker for the ELLPACK matrix engine, bound to the top level.
module esm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic signed [esm_pkg::VAL_W-1:0] out_result_value
);

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != esm_pkg::ST_OK |-> out_result_value == '0)
    else $error("nonzero result with error status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
                               && $stable(out_result_value))
    else $error("result word changed while stalled");

endmodule

bind ellpack_sparse_matrix_engine esm_checker u_esm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_result_value (out_result_value)
);

// ===== tb/ellpack_sparse_matrix_engine_chk.sv =====
// Checker: watches the command and result channels, predicts each result word and compares.
module ellpack_sparse_matrix_engine_chk
  import esm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [2:0]              in_action,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [COL_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              out_status,
  input  logic signed [VAL_W-1:0] out_result_value,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_data,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    st_t                    status;
    logic signed [VAL_W-1:0] value;
  } result_word_t;

  result_word_t predicted_words[$];

  logic [CNT_W-1:0]        row_cnt, col_cnt;
  logic [SPR_W-1:0]        slot_cnt;

  logic [COL_W-1:0]        slot_col[SLOT_TOTAL];
  logic                    slot_vld[SLOT_TOTAL];
  logic signed [VAL_W-1:0] slot_val[SLOT_TOTAL];
  logic signed [VAL_W-1:0] x_vec[MAX_COLS];

  function automatic logic signed [VAL_W-1:0] sat_q16(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[VAL_W-1:0];
  endfunction

  // Apply one command word to the matrix copy and return its result word.
  task automatic ellpack_apply(input act_t a, input int row, input int col,
                               input logic signed [VAL_W-1:0] val,
                               output result_word_t rw);
    int     er, ec, es, s;
    bit     done;
    longint acc, p;
    er = (row_cnt > MAX_ROWS) ? MAX_ROWS : row_cnt;
    ec = (col_cnt > MAX_COLS) ? MAX_COLS : col_cnt;
    es = (slot_cnt > MAX_SLOTS) ? MAX_SLOTS : slot_cnt;
    rw.status = ST_OK;
    rw.value  = '0;
    case (a)
      ACT_SET, ACT_ADD, ACT_GET: begin
        if (row >= er || col >= ec) begin
          rw.status = ST_INDEX;
        end else begin
          done = 0;
          for (int j = 0; j < es && !done; j++) begin
            s = row * MAX_SLOTS + j;
            if (!slot_vld[s]) begin
              if (a != ACT_GET) begin
                slot_vld[s] = 1'b1;
                slot_col[s] = COL_W'(col);
                slot_val[s] = val;
              end
              done = 1;
            end else if (slot_col[s] == col) begin
              if (a == ACT_SET) slot_val[s] = val;
              else if (a == ACT_ADD) slot_val[s] = sat_q16(longint'(slot_val[s]) + longint'(val));
              else rw.value = slot_val[s];
              done = 1;
            end
          end
          if (!done) rw.status = (a == ACT_GET) ? ST_ABSENT : ST_FULL;
        end
      end
      ACT_ZROW: begin
        if (row >= er) begin
          rw.status = ST_INDEX;
        end else begin
          for (int j = 0; j < es; j++) begin
            s = row * MAX_SLOTS + j;
            if (!slot_vld[s]) break;
            slot_val[s] = (slot_col[s] == row) ? val : '0;
          end
        end
      end
      ACT_ZCOL: begin
        if (col >= ec) begin
          rw.status = ST_INDEX;
        end else begin
          for (int i = 0; i < er; i++) begin
            for (int j = 0; j < es; j++) begin
              s = i * MAX_SLOTS + j;
              if (!slot_vld[s]) break;
              if (slot_col[s] == col) slot_val[s] = (i == col) ? val : '0;
            end
          end
        end
      end
      ACT_LOADX: begin
        if (col >= ec) rw.status = ST_INDEX;
        else x_vec[col] = val;
      end
      ACT_PROD: begin
        if (row >= er) begin
          rw.status = ST_INDEX;
        end else begin
          acc = 0;
          for (int j = 0; j < es; j++) begin
            s = row * MAX_SLOTS + j;
            if (!slot_vld[s]) break;
            p = longint'(slot_val[s]) * longint'(x_vec[slot_col[s]]);
            acc += (p >>> 16);   // floor of the exact Q32.32 product to Q16.16
          end
          rw.value = sat_q16(acc);
        end
      end
      default: begin
        for (int k = 0; k < SLOT_TOTAL; k++) slot_vld[k] = 1'b0;
      end
    endcase
  endtask

  assign pending = predicted_words.size();

  always @(posedge clk) begin
    result_word_t rw, exp_w;
    if (!rst_n) begin
      row_cnt  = 11'd1024;
      col_cnt  = 11'd1024;
      slot_cnt = 4'd8;
      for (int k = 0; k < SLOT_TOTAL; k++) slot_vld[k] = 1'b0;
      for (int k = 0; k < MAX_COLS; k++) x_vec[k] = '0;
      predicted_words.delete();
      fail_count = 0;
    end else begin
      // a result can leave while a new word is taken, so check it first
      if (out_valid && out_ready) begin
        if (predicted_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: status %0d value %0d",
                     out_status, out_result_value);
        end else begin
          exp_w = predicted_words.pop_front();
          if (out_status !== exp_w.status || out_result_value !== exp_w.value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected status %0d value %0d, got status %0d value %0d",
                       exp_w.status, exp_w.value, out_status, out_result_value);
          end
        end
      end
      if (in_valid && in_ready) begin
        ellpack_apply(act_t'(in_action), in_row, in_col, in_value, rw);
        predicted_words.push_back(rw);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ROWS:  row_cnt  = cfg_data;
          CFG_COLS:  col_cnt  = cfg_data;
          CFG_SLOTS: slot_cnt = cfg_data[SPR_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/ellpack_sparse_matrix_engine_tb.sv =====
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
module ellpack_sparse_matrix_engine_tb;
  import esm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int NUM_PHASES  = 7;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [2:0]              in_action = '0;
  logic [ROW_W-1:0]        in_row = '0;
  logic [COL_W-1:0]        in_col = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_result_value;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0]       cfg_index = '0;
  logic [CFG_DW-1:0]       cfg_data = '0;

  int fail_count, pending, cycles;
  int burst_left, stall_left, run_left;
  int eff_rows, eff_cols;

  int phase_rows[NUM_PHASES]  = '{16, 1, 300, 0, 2047, 5, 1024};
  int phase_cols[NUM_PHASES]  = '{16, 1, 1024, 0, 2047, 700, 7};
  int phase_slots[NUM_PHASES] = '{4, 1, 8, 0, 15, 2, 3};
  int phase_items[NUM_PHASES] = '{400, 120, 350, 60, 400, 300, 220};

  ellpack_sparse_matrix_engine u_top (.*);

  ellpack_sparse_matrix_engine_chk u_chk (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: runs of ready broken by stalls of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      out_ready <= 1'b1;
      run_left--;
    end else begin
      out_ready <= 1'b1;
      run_left = $urandom_range(0, 40);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input act_t a, input int row, input int col,
                           input logic signed [VAL_W-1:0] val);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid  = 1'b1;
    in_action = a;
    in_row    = ROW_W'(row);
    in_col    = COL_W'(col);
    in_value  = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DW'(data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic int pick_index(input int lim, input int hot);
    int r;
    r = $urandom_range(0, 9);
    if (lim == 0 || r == 0) return $urandom_range(0, 1023);
    if (r == 1) return $urandom_range(0, lim - 1);
    return $urandom_range(0, ((lim < hot) ? lim : hot) - 1);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
    if (r < 8) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return -1;
      default: return 32'sh00010000;
    endcase
  endfunction

  function automatic act_t pick_action;
    int r;
    r = $urandom_range(0, 399);
    if (r < 2) return ACT_CLEAR;
    if (r < 6 || (eff_rows <= 64 && r < 16)) return ACT_ZCOL;
    if (r < 100) return ACT_SET;
    if (r < 180) return ACT_ADD;
    if (r < 240) return ACT_GET;
    if (r < 260) return ACT_ZROW;
    if (r < 310) return ACT_LOADX;
    return ACT_PROD;
  endfunction

  initial begin
    act_t a;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, saturation, full row, absent entry, every action
    send_word(ACT_SET, 0, 0, 32'sh7fffffff);
    send_word(ACT_ADD, 0, 0, 1);
    send_word(ACT_SET, 1023, 1023, 32'sh80000000);
    send_word(ACT_ADD, 1023, 1023, -1);
    send_word(ACT_GET, 0, 0, 0);
    send_word(ACT_GET, 5, 5, 0);
    for (int c = 0; c < 8; c++) send_word(ACT_SET, 2, c + 1, 32'sh00020000 * (c - 3));
    send_word(ACT_SET, 2, 9, 1);
    send_word(ACT_GET, 2, 10, 0);
    send_word(ACT_ADD, 2, 11, 1);
    send_word(ACT_LOADX, 0, 0, 32'sh7fffffff);
    send_word(ACT_LOADX, 0, 1023, 32'sh80000000);
    send_word(ACT_LOADX, 0, 3, 32'sh00030000);
    send_word(ACT_PROD, 0, 0, 0);
    send_word(ACT_PROD, 1023, 0, 0);
    send_word(ACT_PROD, 2, 0, 0);
    send_word(ACT_ZROW, 2, 0, 32'sh00050000);
    send_word(ACT_ZCOL, 0, 1023, -5);
    send_word(ACT_CLEAR, 0, 0, 0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_ROWS, phase_rows[p]);
      write_reg(CFG_COLS, phase_cols[p]);
      write_reg(CFG_SLOTS, phase_slots[p]);
      eff_rows = (phase_rows[p] > MAX_ROWS) ? MAX_ROWS : phase_rows[p];
      eff_cols = (phase_cols[p] > MAX_COLS) ? MAX_COLS : phase_cols[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        a = pick_action();
        send_word(a, pick_index(eff_rows, 6), pick_index(eff_cols, 12), pick_value());
      end
      drain();
    end

    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/esm_pkg.sv
hw/rtl/esm_datapath.sv
hw/rtl/esm_ctrl.sv
hw/rtl/ellpack_sparse_matrix_engine.sv
hw/rtl/esm_checker.sv
tb/ellpack_sparse_matrix_engine_chk.sv
tb/ellpack_sparse_matrix_engine_tb.sv
